### rtl/core/infix_to_postfix_converter_unit_defines.svh
// Assertion macros used by the infix to postfix converter datapath.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define ITP_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/itp_pkg.sv
// Types, constants and helper functions shared by the infix to postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef logic [2:0] code_t;

    localparam code_t CODE_LPAREN = 3'd0;
    localparam code_t CODE_PLUS   = 3'd1;
    localparam code_t CODE_MINUS  = 3'd2;
    localparam code_t CODE_STAR   = 3'd3;
    localparam code_t CODE_SLASH  = 3'd4;

    typedef enum logic [2:0] {
        CLS_DIGIT  = 3'd0,
        CLS_OP     = 3'd1,
        CLS_LPAREN = 3'd2,
        CLS_RPAREN = 3'd3,
        CLS_END    = 3'd4,
        CLS_OTHER  = 3'd5
    } char_class_t;

    typedef enum logic [2:0] {
        EMIT_NONE  = 3'd0,
        EMIT_INPUT = 3'd1,
        EMIT_SPACE = 3'd2,
        EMIT_TOP   = 3'd3,
        EMIT_NUL   = 3'd4
    } emit_sel_t;

    typedef struct packed {
        logic      take;
        logic      latch_flag;
        emit_sel_t emit;
        logic      finish;
        logic      dec;
        logic      push;
        logic      set_num;
        logic      clr_num;
        logic      clear_all;
    } itp_cmd_t;

    typedef struct packed {
        char_class_t cls;
        logic        pop_ok;
        logic        count_zero;
        logic        in_number;
        logic        out_free;
    } itp_status_t;

    function automatic code_t code_of_char(input logic [7:0] ch);
        code_t c;
        case (ch)
            CH_PLUS:  c = CODE_PLUS;
            CH_MINUS: c = CODE_MINUS;
            CH_STAR:  c = CODE_STAR;
            CH_SLASH: c = CODE_SLASH;
            default:  c = CODE_LPAREN;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] char_of_code(input code_t c);
        logic [7:0] ch;
        case (c)
            CODE_LPAREN: ch = CH_LPAREN;
            CODE_PLUS:   ch = CH_PLUS;
            CODE_MINUS:  ch = CH_MINUS;
            CODE_STAR:   ch = CH_STAR;
            CODE_SLASH:  ch = CH_SLASH;
            default:     ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] prec_of_code(input code_t c);
        logic [1:0] p;
        case (c) inside
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_STAR, CODE_SLASH: p = 2'd2;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/itp_datapath.sv
// Datapath of the infix to postfix converter: operator stack, pending slot and output register.
`include "infix_to_postfix_converter_unit_defines.svh"

module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  itp_pkg::itp_cmd_t  cmd,
    output itp_pkg::itp_status_t status,
    input  logic [7:0]         in_char,
    input  logic               in_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               out_last,
    output logic               out_flag
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [7:0]               char_reg;
    logic                     end_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     in_number_reg, in_number_next;
    logic                     ovf_reg, ovf_next;
    logic                     item_flag_reg, item_flag_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [7:0]               pend_char_reg, pend_char_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_char_reg, out_char_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_flag_reg, out_flag_next;
    itp_pkg::code_t           stack_mem [STACK_DEPTH];
    itp_pkg::code_t           rd_data_reg;

    logic [CNT_W-1:0]         count_m1;
    logic [IDX_W-1:0]         rd_addr;
    logic                     count_full;
    logic                     count_zero;
    itp_pkg::char_class_t     cls;
    itp_pkg::code_t           in_code;
    logic                     pop_ok;
    logic                     out_free;
    logic                     move;
    logic                     drop;
    logic [7:0]               emit_char;

    assign count_m1   = count_reg - CNT_W'(1);
    assign rd_addr    = count_m1[IDX_W-1:0];
    assign count_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_zero = (count_reg == '0);
    assign in_code    = itp_pkg::code_of_char(char_reg);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        if (end_reg)
            cls = itp_pkg::CLS_END;
        else if (char_reg >= itp_pkg::CH_ZERO && char_reg <= itp_pkg::CH_NINE)
            cls = itp_pkg::CLS_DIGIT;
        else if (char_reg == itp_pkg::CH_PLUS || char_reg == itp_pkg::CH_MINUS ||
                 char_reg == itp_pkg::CH_STAR || char_reg == itp_pkg::CH_SLASH)
            cls = itp_pkg::CLS_OP;
        else if (char_reg == itp_pkg::CH_LPAREN)
            cls = itp_pkg::CLS_LPAREN;
        else if (char_reg == itp_pkg::CH_RPAREN)
            cls = itp_pkg::CLS_RPAREN;
        else
            cls = itp_pkg::CLS_OTHER;
    end

    always_comb
    begin
        case (cls)
            itp_pkg::CLS_END:
                pop_ok = !count_zero;
            itp_pkg::CLS_OP:
                pop_ok = !count_zero && (itp_pkg::prec_of_code(rd_data_reg) >=
                                         itp_pkg::prec_of_code(in_code));
            itp_pkg::CLS_RPAREN:
                pop_ok = !count_zero && (rd_data_reg != itp_pkg::CODE_LPAREN);
            default:
                pop_ok = 1'b0;
        endcase
    end

    // An operator that pops nothing, or a '(', is dropped when the stack is full.
    assign drop = count_full && ((cls == itp_pkg::CLS_LPAREN) ||
                                 (cls == itp_pkg::CLS_OP && !pop_ok));

    always_comb
    begin
        case (cmd.emit)
            itp_pkg::EMIT_INPUT: emit_char = char_reg;
            itp_pkg::EMIT_SPACE: emit_char = itp_pkg::CH_SPACE;
            itp_pkg::EMIT_TOP:   emit_char = itp_pkg::char_of_code(rd_data_reg);
            default:             emit_char = itp_pkg::CH_NUL;
        endcase
    end

    assign move = pend_valid_reg && ((cmd.emit != itp_pkg::EMIT_NONE) || cmd.finish);

    always_comb
    begin
        count_next      = count_reg;
        in_number_next  = in_number_reg;
        ovf_next        = ovf_reg;
        item_flag_next  = item_flag_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_flag_next   = out_flag_reg;

        if (cmd.latch_flag)
        begin
            item_flag_next = ovf_reg || drop;
            ovf_next       = ovf_reg || drop;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            out_char_next  = pend_char_reg;
            out_last_next  = cmd.finish;
            out_flag_next  = item_flag_reg;
        end
        if (cmd.emit != itp_pkg::EMIT_NONE)
        begin
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
        if (cmd.finish)
            pend_valid_next = 1'b0;
        if (cmd.set_num)
            in_number_next = 1'b1;
        if (cmd.clr_num)
            in_number_next = 1'b0;
        if (cmd.dec)
            count_next = count_m1;
        if (cmd.push && !count_full)
            count_next = count_reg + CNT_W'(1);
        if (cmd.clear_all)
        begin
            count_next     = '0;
            in_number_next = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            in_number_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            in_number_reg  <= in_number_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            char_reg <= in_char;
            end_reg  <= in_end;
        end
        item_flag_reg <= item_flag_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_flag_reg  <= out_flag_next;
    end

    // Operator stack: at most one write and one registered read at the top each cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push && !count_full)
            stack_mem[count_reg[IDX_W-1:0]] <= in_code;
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign status.cls        = cls;
    assign status.pop_ok     = pop_ok;
    assign status.count_zero = count_zero;
    assign status.in_number  = in_number_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_flag  = out_flag_reg;

    `ITP_ASSERT(a_count_range, count_reg <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `ITP_ASSERT_IMP(a_move_free, move, out_free, "request moved into a busy output register")
    `ITP_ASSERT_IMP(a_take_empty, cmd.take, !pend_valid_reg, "new item taken with a result pending")
    `ITP_ASSERT_NEXT(a_end_clears, cmd.finish && end_reg, count_reg == '0 && !ovf_reg,
        "end of expression did not clear the state")

endmodule

### rtl/core/itp_ctrl.sv
// Controller state machine of the infix to postfix converter.
module itp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itp_pkg::itp_status_t status,
    output itp_pkg::itp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DECODE    = 11'b000_0000_0010,
        S_DIGIT     = 11'b000_0000_0100,
        S_SPACE     = 11'b000_0000_1000,
        S_CHECK     = 11'b000_0001_0000,
        S_POP_CHAR  = 11'b000_0010_0000,
        S_POP_SPACE = 11'b000_0100_0000,
        S_PUSH      = 11'b000_1000_0000,
        S_DISCARD   = 11'b001_0000_0000,
        S_TERM      = 11'b010_0000_0000,
        S_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t after_close;

    // Where an item goes once any open digit run has been closed.
    always_comb
    begin
        case (status.cls) inside
            itp_pkg::CLS_END, itp_pkg::CLS_OP, itp_pkg::CLS_RPAREN: after_close = S_CHECK;
            itp_pkg::CLS_LPAREN: after_close = S_PUSH;
            default:             after_close = S_FINISH;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = itp_pkg::EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.latch_flag = 1'b1;
                if (status.cls == itp_pkg::CLS_DIGIT)
                    state_next = S_DIGIT;
                else if (status.in_number)
                    state_next = S_SPACE;
                else
                    state_next = after_close;
            end
            S_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = itp_pkg::EMIT_INPUT;
                    cmd.set_num = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SPACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = itp_pkg::EMIT_SPACE;
                    cmd.clr_num = 1'b1;
                    state_next  = after_close;
                end
            end
            S_CHECK:
            begin
                if (status.pop_ok)
                    state_next = S_POP_CHAR;
                else
                begin
                    case (status.cls)
                        itp_pkg::CLS_END:    state_next = S_TERM;
                        itp_pkg::CLS_OP:     state_next = S_PUSH;
                        itp_pkg::CLS_RPAREN:
                            state_next = status.count_zero ? S_FINISH : S_DISCARD;
                        default:             state_next = S_FINISH;
                    endcase
                end
            end
            S_POP_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = itp_pkg::EMIT_TOP;
                    cmd.dec    = 1'b1;
                    state_next = S_POP_SPACE;
                end
            end
            S_POP_SPACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = itp_pkg::EMIT_SPACE;
                    state_next = S_CHECK;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_FINISH;
            end
            S_DISCARD:
            begin
                cmd.dec    = 1'b1;
                state_next = S_FINISH;
            end
            S_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = itp_pkg::EMIT_NUL;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish    = 1'b1;
                    cmd.clear_all = (status.cls == itp_pkg::CLS_END);
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

### rtl/core/infix_to_postfix_converter_unit.sv
// Top level of the infix to postfix converter: stream ports, controller and datapath.
//
// This block turns an infix expression, one ASCII character per input request, into its
// postfix form, one character per output request, by the shunting-yard method. Digit runs
// are copied through and closed by a space; operators and '(' go onto a stack of
// STACK_DEPTH entries and leave it, each followed by a space, by precedence ('*' and '/'
// above '+' and '-'); ')' unwinds the stack to the matching '('. An input request with
// tlast high ends the expression: the stack is flushed, a NUL terminator is sent and all
// state is cleared. Output tlast marks the final output request caused by an input request,
// and output tuser carries the sticky overflow flag, set once an operator or '(' has been
// dropped because the stack was full. The block works on one input request at a time: it
// accepts and decodes a request, emits each direct character, pops each operator off the
// stack and sends it with a space, runs the precedence test that ends the popping,
// pushes, and closes out the request. Each pop emits the space before the next precedence
// test, so that the stack memory's registered read port can settle on the new top. A full
// output register holds the sequencer until the downstream side takes it. No clearing pass
// is needed after reset.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // Input requests.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // end_of_expr
    // Output requests.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // last
    output logic       m_axis_tuser    // [0] overflow
);

    itp_pkg::itp_cmd_t    cmd;
    itp_pkg::itp_status_t status;

    // The controller sequences each request through decode, pops, push and close-out.
    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the stack, the digit-run and overflow flags, a one-deep pending
    // slot that lets the final output of a request be marked with tlast, and the output
    // register.
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_char   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_flag  (m_axis_tuser)
    );

endmodule

### test/postfix_checker.sv
// Watches both stream channels of the converter, predicts its postfix output and compares.
`timescale 1ns / 100ps

module postfix_checker #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // end_of_expr
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_char
    input  logic       m_axis_tlast,   // last
    input  logic       m_axis_tuser,   // [0] overflow
    output int         fail_count,
    output int         pending
);

    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] glyph;
        logic       last;
        logic       overflow;
    } postfix_char_t;

    // Own copy of the converter state.
    code_t       op_stack [STACK_DEPTH];
    int unsigned depth;
    logic        in_run;
    logic        overflow_seen;

    logic [7:0]    emitted [$];
    postfix_char_t postfix_q [$];

    function automatic int binding(input code_t c);
        int r;
        case (c)
            CODE_STAR, CODE_SLASH: r = 2;
            CODE_PLUS, CODE_MINUS: r = 1;
            default:               r = 0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] glyph_of(input code_t c);
        logic [7:0] g;
        case (c)
            CODE_PLUS:  g = CH_PLUS;
            CODE_MINUS: g = CH_MINUS;
            CODE_STAR:  g = CH_STAR;
            CODE_SLASH: g = CH_SLASH;
            default:    g = CH_LPAREN;
        endcase
        return g;
    endfunction

    task automatic pop_top();
        depth--;
        emitted.push_back(glyph_of(op_stack[depth]));
        emitted.push_back(CH_SPACE);
    endtask

    task automatic push_code(input code_t c);
        if (depth >= STACK_DEPTH)
            overflow_seen = 1'b1;
        else
        begin
            op_stack[depth] = c;
            depth++;
        end
    endtask

    // Works out the characters that one accepted request produces.
    task automatic convert_char(input logic [7:0] ch, input logic fin);
        code_t         code;
        bit            is_op;
        postfix_char_t item;
        emitted.delete();
        is_op = 1'b1;
        case (ch)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_STAR:  code = CODE_STAR;
            CH_SLASH: code = CODE_SLASH;
            default:
            begin
                is_op = 1'b0;
                code  = CODE_LPAREN;
            end
        endcase
        if (!fin && ch >= CH_ZERO && ch <= CH_NINE)
        begin
            in_run = 1'b1;
            emitted.push_back(ch);
        end
        else
        begin
            if (in_run)
            begin
                in_run = 1'b0;
                emitted.push_back(CH_SPACE);
            end
            if (fin)
            begin
                while (depth > 0)
                    pop_top();
                emitted.push_back(CH_NUL);
            end
            else if (is_op)
            begin
                while (depth > 0 && binding(op_stack[depth - 1]) >= binding(code))
                    pop_top();
                push_code(code);
            end
            else if (ch == CH_LPAREN)
                push_code(CODE_LPAREN);
            else if (ch == CH_RPAREN)
            begin
                while (depth > 0 && op_stack[depth - 1] != CODE_LPAREN)
                    pop_top();
                if (depth > 0)
                    depth--;
            end
        end
        foreach (emitted[i])
        begin
            item.glyph    = emitted[i];
            item.last     = (i == emitted.size() - 1);
            item.overflow = overflow_seen;
            postfix_q.push_back(item);
        end
        if (fin)
        begin
            depth         = 0;
            in_run        = 1'b0;
            overflow_seen = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : watch
        postfix_char_t want;
        if (!rst_n)
        begin
            depth         = 0;
            in_run        = 1'b0;
            overflow_seen = 1'b0;
            postfix_q.delete();
            fail_count    = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                convert_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (postfix_q.size() == 0)
                    report_mismatch($sformatf("unexpected output request, char %h",
                                              m_axis_tdata));
                else
                begin
                    want = postfix_q.pop_front();
                    if (m_axis_tdata !== want.glyph)
                        report_mismatch($sformatf("out_char %h, expected %h",
                                                  m_axis_tdata, want.glyph));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b (char %h)",
                                                  m_axis_tlast, want.last, want.glyph));
                    if (m_axis_tuser !== want.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b (char %h)",
                                                  m_axis_tuser, want.overflow, want.glyph));
                end
            end
        end
        pending = postfix_q.size();
    end

endmodule

### test/tb.sv
// Top of the converter testbench: clock, reset, request stimulus and the final verdict.
`timescale 1ns / 100ps

module tb;

    import itp_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } keystroke_t;

    // Patterns that the downstream side cycles through when taking results.
    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_RANDOM   = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_SPARSE   = 2'd3
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       m_axis_tuser;

    int fail_count;
    int pending;

    // Requests waiting to be offered, and how many requests have been queued so far.
    keystroke_t script [$];
    int         counted = 0;
    int         burst_left = 0;
    int         hold_req = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    postfix_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    function automatic logic [7:0] any_operator();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0:       ch = CH_PLUS;
            1:       ch = CH_MINUS;
            2:       ch = CH_STAR;
            default: ch = CH_SLASH;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic queue_char(input logic [7:0] ch);
        script.push_back('{code: ch, fin: 1'b0});
        counted++;
    endtask

    // The end request carries a random character, which the block must ignore.
    task automatic queue_end();
        script.push_back('{code: 8'($urandom_range(0, 255)), fin: 1'b1});
        counted++;
    endtask

    task automatic queue_text(input string s);
        foreach (s[i])
            queue_char(s[i]);
    endtask

    // Now and then a stray character turns up in the middle of an expression.
    task automatic maybe_stray();
        if ($urandom_range(0, 19) == 0)
            queue_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
    endtask

    // A well-formed expression with random numbers, operators and bracket nesting. A few
    // leave a bracket open or add a stray closing one.
    task automatic add_expr();
        int terms;
        int open;
        int t;
        int n;
        terms = $urandom_range(1, 8);
        open  = 0;
        for (t = 0; t < terms; t++)
        begin
            while (open < 4 && $urandom_range(0, 3) == 0)
            begin
                queue_char(CH_LPAREN);
                open++;
            end
            for (n = $urandom_range(1, 3); n > 0; n--)
                queue_char(any_digit());
            maybe_stray();
            while (open > 0 && $urandom_range(0, 2) == 0)
            begin
                queue_char(CH_RPAREN);
                open--;
            end
            if (t < terms - 1)
            begin
                queue_char(any_operator());
                maybe_stray();
            end
        end
        if ($urandom_range(0, 9) != 0)
            for (; open > 0; open--)
                queue_char(CH_RPAREN);
        if ($urandom_range(0, 9) == 0)
            queue_char(CH_RPAREN);
        queue_end();
    endtask

    // Deep nesting that drives the operator stack towards, and past, its full depth.
    task automatic add_nest(input int levels);
        int l;
        int closes;
        for (l = 0; l < levels; l++)
        begin
            queue_char(CH_LPAREN);
            if ($urandom_range(0, 1))
            begin
                queue_char(any_digit());
                queue_char(any_operator());
            end
        end
        queue_char(any_digit());
        for (closes = $urandom_range(0, levels); closes > 0; closes--)
        begin
            queue_char(CH_RPAREN);
            if ($urandom_range(0, 2) == 0)
            begin
                queue_char(any_operator());
                queue_char(any_digit());
            end
        end
        queue_end();
    endtask

    // Broken sequences: random bytes, biased towards the characters that do something.
    task automatic add_noise();
        int n;
        for (n = $urandom_range(1, 10); n > 0; n--)
        begin
            case ($urandom_range(0, 9))
                0:       queue_char(any_operator());
                1:       queue_char(CH_LPAREN);
                2:       queue_char(CH_RPAREN);
                3:       queue_char(any_digit());
                default: queue_char(8'($urandom_range(0, 255)));
            endcase
        end
        queue_end();
    endtask

    // Offers one request and waits for it to be taken. Requests go out in bursts of random
    // length, some of them long, with random gaps in between.
    task automatic offer(input keystroke_t k);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tdata  <= k.code;
        s_axis_tlast  <= k.fin;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic play();
        foreach (script[i])
            offer(script[i]);
        script.delete();
    endtask

    // Stops offering and waits until every expected result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Downstream side. It runs through spans of differing readiness and, when asked, holds
    // off for a long stretch so that the converter backs up and stalls its input.
    initial
    begin : receiver
        rx_mode_t mode;
        int       span;
        int       period;
        int       c;
        int       hold_ack;
        int       hold_cnt;
        logic     rdy;
        hold_ack = 0;
        hold_cnt = 0;
        forever
        begin
            mode   = rx_mode_t'($urandom_range(0, 3));
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 5);
            for (c = 0; c < span; c++)
            begin
                @(posedge clk);
                if (hold_req != hold_ack)
                begin
                    hold_ack = hold_req;
                    hold_cnt = HOLD_CYCLES;
                end
                if (hold_cnt > 0)
                begin
                    hold_cnt--;
                    rdy = 1'b0;
                end
                else
                begin
                    case (mode)
                        RX_OPEN:     rdy = 1'b1;
                        RX_RANDOM:   rdy = ($urandom_range(0, 9) < 6);
                        RX_PERIODIC: rdy = (c % period == 0);
                        default:     rdy = ($urandom_range(0, 3) == 0);
                    endcase
                end
                m_axis_tready <= rdy;
            end
        end
    end

    initial
    begin : stimulus
        bit held;
        bit paused;
        int pick;
        held   = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: digit runs closed by an operator, by ')' and by the end request;
        // both precedence levels; an unmatched ')'; skipped characters at both extremes of
        // the byte; an unmatched '(' flushed at the end; and an empty expression.
        queue_text("9*(0-1)/2)");
        queue_char(8'hFF);
        queue_char(8'h00);
        queue_text("(+7");
        queue_end();
        queue_end();
        play();
        drain();

        // The first deep nest always overruns the stack, so the overflow flag is seen.
        add_nest(DEPTH + 4);
        play();

        while (counted < 310)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                add_expr();
            else if (pick < 17)
                add_nest($urandom_range(6, DEPTH + 4));
            else
                add_noise();
            // Once in the run the receiver holds off while a long burst keeps coming.
            if (!held && counted >= 100)
            begin
                held = 1'b1;
                hold_req++;
                burst_left = 90;
            end
            play();
            if (!paused && counted >= 200)
            begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("infix_to_postfix_converter_unit test passed");
        else
            $display("infix_to_postfix_converter_unit test failed");
        $finish;
    end

    initial
    begin : watchdog
        #12_000_000;
        $display("infix_to_postfix_converter_unit test failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/itp_pkg.sv
rtl/core/itp_datapath.sv
rtl/core/itp_ctrl.sv
rtl/core/infix_to_postfix_converter_unit.sv
test/postfix_checker.sv
test/tb.sv
